[src/bezier_sprite_path_stepper_macros.svh]
// Assertion macros shared by the sprite path stepper RTL.
`ifndef BEZIER_SPRITE_PATH_STEPPER_MACROS_SVH
`define BEZIER_SPRITE_PATH_STEPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bsps_pkg.sv]
// Types, codes and helpers for the Bezier sprite path stepper.
package bsps_pkg;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 72;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 66;
  localparam int ACC_W      = 72;
  localparam int MAG_W      = 57;
  localparam int T2_W       = 40;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [11:0] WIDTH_RESET  = 12'd80;
  localparam logic [11:0] HEIGHT_RESET = 12'd24;

  // Curve parameter value 1.0 in Q8.24.
  localparam logic signed [31:0] T_ONE = 32'sh0100_0000;

  // Steps of the per-coordinate multiply sequence.
  localparam logic [3:0] STEP_BT     = 4'd0;
  localparam logic [3:0] STEP_AT_LO  = 4'd1;
  localparam logic [3:0] STEP_AT_HI  = 4'd2;
  localparam logic [3:0] STEP_SUM    = 4'd3;
  localparam logic [3:0] STEP_MAG    = 4'd4;
  localparam logic [3:0] STEP_SC_LO  = 4'd5;
  localparam logic [3:0] STEP_SC_HI  = 4'd6;
  localparam logic [3:0] STEP_SC_SUM = 4'd7;
  localparam logic [3:0] STEP_SAT    = 4'd8;

  typedef struct packed {
    logic        last;
    logic [31:0] accel;
    logic [31:0] speed;
    logic [15:0] end_y;
    logic [15:0] end_x;
    logic [15:0] ctrl_y;
    logic [15:0] ctrl_x;
    logic [15:0] start_y;
    logic [15:0] start_x;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_RD_CUR  = 7'b0000010,
    ST_RD_NXT  = 7'b0000100,
    ST_CALC    = 7'b0001000,
    ST_UPDATE  = 7'b0010000,
    ST_DONE    = 7'b0100000,
    ST_RESTART = 7'b1000000
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/bsps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/bezier_sprite_path_stepper.sv]
// Bezier sprite path stepper: segment table, curve evaluation and motion update.
//
// Input items arrive on the s_ channel; s_tuser carries the mode (load segment,
// tick, restart) and s_tlast the last-segment mark of a load. A load writes one
// table entry; a restart goes through a restart state (it reads the
// speed of entry zero). A tick produces one result item on the m_ channel:
// new and previous position, segment, with m_tuser the screen-clear flag and
// m_tlast the done flag. A tick on a finished path goes straight to the done state.
// Otherwise a tick passes from acceptance to m_tvalid through two table
// reads (current and following entry), then nine steps per coordinate through
// one shared 33x33 multiplier with a product register, then the t and speed
// update. The block takes no new item until that result sits in the output
// register, so no new tick is taken while one is computed. The output register
// holds its item while m_tready is low; loads and restarts are still taken
// meanwhile, and a further tick is computed but keeps its result until then.
// Reset is synchronous; it sets screen size 80 x 24, segment 0, t and speed 0
// and marks the path finished. Table contents are undefined until loaded.
// The configuration port writes the screen width (index 0) and height (1).
`include "bezier_sprite_path_stepper_macros.svh"

module bezier_sprite_path_stepper #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // seg_index[3:0], start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, speed_step,
  // accel_step, zero pad[167:164]
  input  logic [167:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, prev_x, prev_y, sprite_seg[67:64], zero pad[71:68]
  output logic [71:0]  m_tdata,
  // clear_screen[0]
  output logic [0:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [11:0]  cfg_data
);

  localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int IDX_W = (SEG_W > 4) ? SEG_W : 4;

  bsps_pkg::state_t state;

  logic [3:0]                     step;
  logic                           coord;
  logic [SEG_W-1:0]               cur_seg;
  logic signed [31:0]             curve_param;
  logic signed [31:0]             cur_speed;
  logic [15:0]                    old_x;
  logic [15:0]                    old_y;
  logic                           finished;
  logic [11:0]                    screen_width;
  logic [11:0]                    screen_height;

  logic [15:0]                    p0x, p0y, p1x, p1y, p2x, p2y;
  logic signed [31:0]             accel_q;
  logic                           last_q;
  logic signed [31:0]             nxt_speed;

  logic signed [bsps_pkg::PROD_W-1:0] prod;
  logic signed [bsps_pkg::ACC_W-1:0]  acc;
  logic [bsps_pkg::T2_W-1:0]          t2;
  logic [bsps_pkg::MAG_W-1:0]         mag;
  logic                               neg;
  logic [15:0]                        px, py;

  logic [15:0] res_pos_x, res_pos_y, res_prev_x, res_prev_y;
  logic [3:0]  res_seg;
  logic        res_clear;
  logic        res_done;

  // Input decode.
  logic                          s_accept;
  logic [1:0]                    in_mode;
  logic [IDX_W-1:0]              idx_ext;
  logic                          idx_ok;
  bsps_pkg::seg_entry_t          in_entry;
  logic [bsps_pkg::ENTRY_W-1:0]  rd_raw;
  bsps_pkg::seg_entry_t          rd_entry;
  logic                          ram_we;
  logic [SEG_W-1:0]              rd_addr;
  logic [SEG_W-1:0]              nxt_seg;
  logic [IDX_W-1:0]              seg_ext;

  assign s_tready = (state == bsps_pkg::ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign in_mode  = s_tuser;
  assign idx_ext  = IDX_W'(s_tdata[3:0]);
  assign idx_ok   = (32'(idx_ext) < 32'(MAX_SEGMENTS));
  assign ram_we   = s_accept && (in_mode == bsps_pkg::MODE_LOAD) && idx_ok;
  assign rd_entry = bsps_pkg::seg_entry_t'(rd_raw);
  assign seg_ext  = IDX_W'(cur_seg);
  assign nxt_seg  = (32'(cur_seg) == 32'(MAX_SEGMENTS - 1)) ? '0 : cur_seg + SEG_W'(1);

  always_comb begin
    in_entry.start_x = s_tdata[19:4];
    in_entry.start_y = s_tdata[35:20];
    in_entry.ctrl_x  = s_tdata[51:36];
    in_entry.ctrl_y  = s_tdata[67:52];
    in_entry.end_x   = s_tdata[83:68];
    in_entry.end_y   = s_tdata[99:84];
    in_entry.speed   = s_tdata[131:100];
    in_entry.accel   = s_tdata[163:132];
    in_entry.last    = s_tlast;
  end

  // While idle the read port looks at the entry a tick or restart needs next.
  always_comb begin
    case (state)
      bsps_pkg::ST_RD_CUR: rd_addr = nxt_seg;
      default:             rd_addr = (in_mode == bsps_pkg::MODE_RESTART) ? '0 : cur_seg;
    endcase
  end

  bsps_ram #(
    .WIDTH(bsps_pkg::ENTRY_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(idx_ext[SEG_W-1:0]),
    .wr_data(in_entry),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  // Coordinate being evaluated and its polynomial coefficients.
  logic [15:0]        c_p0, c_p1, c_p2;
  logic [11:0]        c_scale;
  logic signed [17:0] c_a, c_b;
  logic [31:0]        t_mag;

  assign c_p0    = coord ? p0y : p0x;
  assign c_p1    = coord ? p1y : p1x;
  assign c_p2    = coord ? p2y : p2x;
  assign c_scale = coord ? screen_height : screen_width;
  assign c_a     = $signed({2'b00, c_p0}) - $signed({1'b0, c_p1, 1'b0})
                   + $signed({2'b00, c_p2});
  assign c_b     = $signed({1'b0, c_p1, 1'b0}) - $signed({1'b0, c_p0, 1'b0});
  assign t_mag   = curve_param[31] ? (32'd0 - curve_param) : curve_param;

  // Shared multiplier operand selection.
  logic signed [bsps_pkg::MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == bsps_pkg::ST_RD_CUR) begin
      mul_a = {1'b0, t_mag};
      mul_b = {1'b0, t_mag};
    end else if (state == bsps_pkg::ST_CALC) begin
      case (step)
        bsps_pkg::STEP_BT: begin
          mul_a = bsps_pkg::MUL_W'(c_b);
          mul_b = bsps_pkg::MUL_W'(curve_param);
        end
        bsps_pkg::STEP_AT_LO: begin
          mul_a = bsps_pkg::MUL_W'(c_a);
          mul_b = {9'd0, t2[23:0]};
        end
        bsps_pkg::STEP_AT_HI: begin
          mul_a = bsps_pkg::MUL_W'(c_a);
          mul_b = {17'd0, t2[39:24]};
        end
        bsps_pkg::STEP_SC_LO: begin
          mul_a = {1'b0, mag[31:0]};
          mul_b = {21'd0, c_scale};
        end
        bsps_pkg::STEP_SC_HI: begin
          mul_a = {8'd0, mag[56:32]};
          mul_b = {21'd0, c_scale};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Scaled magnitude in whole pixels, then saturation to 16 bits.
  logic [31:0] q;
  logic [15:0] sat_val;

  assign q = acc[71:40];

  always_comb begin
    if (neg) begin
      sat_val = (q > 32'd32768) ? 16'h8000 : 16'(32'd0 - q);
    end else begin
      sat_val = (q > 32'd32767) ? 16'h7FFF : q[15:0];
    end
  end

  // Motion update.
  logic [31:0] t_new, spd_new;
  logic        upd_past;

  assign t_new    = bsps_pkg::sat32(33'(curve_param) + 33'(cur_speed));
  assign spd_new  = bsps_pkg::sat32(33'(cur_speed) + 33'(accel_q));
  assign upd_past = ($signed(t_new) > bsps_pkg::T_ONE);

  // The finished result moves into the output register when that is free.
  logic out_load;

  assign out_load = (state == bsps_pkg::ST_DONE) && (!m_tvalid || m_tready);

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state)
      bsps_pkg::ST_IDLE: begin
        if (s_accept && in_mode == bsps_pkg::MODE_TICK && finished) begin
          res_pos_x  <= old_x;
          res_pos_y  <= old_y;
          res_prev_x <= old_x;
          res_prev_y <= old_y;
          res_seg    <= seg_ext[3:0];
          res_clear  <= 1'b0;
          res_done   <= 1'b1;
        end
      end
      bsps_pkg::ST_RD_CUR: begin
        p0x     <= rd_entry.start_x;
        p0y     <= rd_entry.start_y;
        p1x     <= rd_entry.ctrl_x;
        p1y     <= rd_entry.ctrl_y;
        p2x     <= rd_entry.end_x;
        p2y     <= rd_entry.end_y;
        accel_q <= rd_entry.accel;
        last_q  <= rd_entry.last;
      end
      bsps_pkg::ST_RD_NXT: begin
        // A segment that is not last ends where the following entry starts.
        if (!last_q) begin
          p2x <= rd_entry.start_x;
          p2y <= rd_entry.start_y;
        end
        nxt_speed <= rd_entry.speed;
        t2        <= prod[63:24];
      end
      bsps_pkg::ST_CALC: begin
        case (step)
          bsps_pkg::STEP_AT_LO:
            acc <= $signed({32'd0, c_p0, 24'd0}) + bsps_pkg::ACC_W'(prod);
          bsps_pkg::STEP_AT_HI:
            acc <= acc + bsps_pkg::ACC_W'(prod);
          bsps_pkg::STEP_SUM:
            acc <= acc + (bsps_pkg::ACC_W'(prod) <<< 24);
          bsps_pkg::STEP_MAG: begin
            neg <= acc[bsps_pkg::ACC_W-1];
            mag <= acc[bsps_pkg::ACC_W-1] ? bsps_pkg::MAG_W'(-acc) : bsps_pkg::MAG_W'(acc);
          end
          bsps_pkg::STEP_SC_HI:
            acc <= bsps_pkg::ACC_W'(prod);
          bsps_pkg::STEP_SC_SUM:
            acc <= acc + (bsps_pkg::ACC_W'(prod) <<< 32);
          bsps_pkg::STEP_SAT: begin
            if (coord) begin
              py <= sat_val;
            end else begin
              px <= sat_val;
            end
          end
          default: begin
          end
        endcase
      end
      bsps_pkg::ST_UPDATE: begin
        res_pos_x  <= px;
        res_pos_y  <= py;
        res_prev_x <= old_x;
        res_prev_y <= old_y;
        res_seg    <= seg_ext[3:0];
        res_clear  <= upd_past && !last_q;
        res_done   <= upd_past && last_q;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bsps_pkg::ST_IDLE;
      step          <= bsps_pkg::STEP_BT;
      coord         <= 1'b0;
      cur_seg       <= '0;
      curve_param   <= '0;
      cur_speed     <= '0;
      old_x         <= '0;
      old_y         <= '0;
      finished      <= 1'b1;
      screen_width  <= bsps_pkg::WIDTH_RESET;
      screen_height <= bsps_pkg::HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bsps_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          bsps_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        bsps_pkg::ST_IDLE: begin
          if (s_accept) begin
            case (in_mode)
              bsps_pkg::MODE_TICK:    state <= finished ? bsps_pkg::ST_DONE
                                                        : bsps_pkg::ST_RD_CUR;
              bsps_pkg::MODE_RESTART: state <= bsps_pkg::ST_RESTART;
              default:                state <= bsps_pkg::ST_IDLE;
            endcase
          end
        end
        bsps_pkg::ST_RD_CUR: begin
          state <= bsps_pkg::ST_RD_NXT;
        end
        bsps_pkg::ST_RD_NXT: begin
          state <= bsps_pkg::ST_CALC;
          step  <= bsps_pkg::STEP_BT;
          coord <= 1'b0;
        end
        bsps_pkg::ST_CALC: begin
          if (step == bsps_pkg::STEP_SAT) begin
            step <= bsps_pkg::STEP_BT;
            if (coord) begin
              coord <= 1'b0;
              state <= bsps_pkg::ST_UPDATE;
            end else begin
              coord <= 1'b1;
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        bsps_pkg::ST_UPDATE: begin
          old_x <= px;
          old_y <= py;
          if (upd_past && !last_q) begin
            cur_seg     <= nxt_seg;
            curve_param <= '0;
            cur_speed   <= nxt_speed;
          end else begin
            curve_param <= t_new;
            cur_speed   <= spd_new;
            if (upd_past) begin
              finished <= 1'b1;
            end
          end
          state <= bsps_pkg::ST_DONE;
        end
        bsps_pkg::ST_DONE: begin
          if (out_load) begin
            state <= bsps_pkg::ST_IDLE;
          end
        end
        bsps_pkg::ST_RESTART: begin
          cur_seg     <= '0;
          curve_param <= '0;
          cur_speed   <= rd_entry.speed;
          old_x       <= '0;
          old_y       <= '0;
          finished    <= 1'b0;
          state       <= bsps_pkg::ST_IDLE;
        end
        default: begin
          state <= bsps_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Output valid: set when a result moves in, cleared when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload register, loaded when the finished result moves out.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'd0, res_seg, res_prev_y, res_prev_x, res_pos_y, res_pos_x};
      m_tuser <= res_clear;
      m_tlast <= res_done;
    end
  end

  `BSPS_ASSERT_IMPLY(a_clear_excludes_done, clk, rst, m_tvalid, !(m_tuser[0] && m_tlast), "result flags both screen clear and done")
  `BSPS_ASSERT_IMPLY(a_step_in_range, clk, rst, state == bsps_pkg::ST_CALC, step <= bsps_pkg::STEP_SAT, "multiply sequence step out of range")
  `BSPS_ASSERT_NEXT(a_finished_tick, clk, rst, s_accept && in_mode == bsps_pkg::MODE_TICK && finished, state == bsps_pkg::ST_DONE && res_done, "tick on finished path did not report done")
  `BSPS_ASSERT_NEXT(a_segment_entry, clk, rst, state == bsps_pkg::ST_UPDATE && upd_past && !last_q, curve_param == '0 && res_clear, "moving to next segment did not restart t")

endmodule
